// ----- rtl/core/bine_pkg.sv -----
// shared types and constants for the b+ tree internal node engine
// no dependencies; imported by the interfaces, the sequencer and the top level
package bine_pkg;

	localparam int MAX_ENTRIES_DEF = 512;
	localparam int KEY_BITS_DEF    = 32;

	localparam int FUNC_W   = 3;
	localparam int KEY_W    = 32;
	localparam int CHILD_W  = 31;
	localparam int SLOT_W   = 9;
	localparam int COUNT_W  = 10;
	localparam int STATUS_W = 3;

	typedef enum logic [FUNC_W-1:0] {
		FN_LOOKUP    = 3'd0,
		FN_POPULATE  = 3'd1,
		FN_INSERT    = 3'd2,
		FN_REMOVE    = 3'd3,
		FN_TAKE_ONLY = 3'd4,
		FN_FIND      = 3'd5,
		FN_READ      = 3'd6,
		FN_WRITE_KEY = 3'd7
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK         = 3'd0,
		ST_NOT_FOUND  = 3'd1,
		ST_FULL       = 3'd2,
		ST_BAD_SLOT   = 3'd3,
		ST_NOT_SINGLE = 3'd4
	} status_t;

	typedef struct packed {
		logic [CHILD_W-1:0] child_out;
		logic [KEY_W-1:0]   key_out;
		logic [SLOT_W-1:0]  slot_out;
		logic [COUNT_W-1:0] entry_count;
		status_t            status;
	} result_t;

endpackage

// ----- rtl/core/bine_req_if.sv -----
// request channel: valid/ready handshake with one operation per transfer
// depends on bine_pkg for field widths
interface bine_req_if import bine_pkg::*; ();

	logic               valid;
	logic               ready;
	logic [FUNC_W-1:0]  func;
	logic [KEY_W-1:0]   key_value;
	logic [CHILD_W-1:0] anchor_child;
	logic [CHILD_W-1:0] new_child;
	logic [SLOT_W-1:0]  slot;

	modport source (
		output valid, func, key_value, anchor_child, new_child, slot,
		input  ready
	);

	modport sink (
		input  valid, func, key_value, anchor_child, new_child, slot,
		output ready
	);

endinterface

// ----- rtl/core/bine_rsp_if.sv -----
// result channel: valid/ready handshake with one result per transfer
// depends on bine_pkg for field widths
interface bine_rsp_if import bine_pkg::*; ();

	logic                valid;
	logic                ready;
	logic [CHILD_W-1:0]  child_out;
	logic [KEY_W-1:0]    key_out;
	logic [SLOT_W-1:0]   slot_out;
	logic [COUNT_W-1:0]  entry_count;
	logic [STATUS_W-1:0] status;

	modport source (
		output valid, child_out, key_out, slot_out, entry_count, status,
		input  ready
	);

	modport sink (
		input  valid, child_out, key_out, slot_out, entry_count, status,
		output ready
	);

endinterface

// ----- rtl/core/bine_entry_ram.sv -----
// entry memory: one write port, one read port with registered read data
// no dependencies
module bine_entry_ram #(
	parameter int DEPTH = 512,
	parameter int WIDTH = 63,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/core/bine_ctrl.sv -----
// sequencer for the node engine: walks the entry memory one entry per cycle
// for scans and shifts, with a single key/child compare unit
// depends on bine_pkg and bine_req_if
module bine_ctrl import bine_pkg::*; #(
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
	parameter int KEY_BITS = KEY_BITS_DEF,
	localparam int IDX_W = $clog2(MAX_ENTRIES),
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1),
	localparam int EW = KEY_BITS + CHILD_W
) (
	input  logic             clk,
	input  logic             arst_n,
	bine_req_if.sink         req,
	output logic             mem_we,
	output logic [IDX_W-1:0] mem_waddr,
	output logic [EW-1:0]    mem_wdata,
	output logic [IDX_W-1:0] mem_raddr,
	input  logic [EW-1:0]    mem_rdata,
	input  logic             res_free,
	output logic             res_vld,
	output result_t          res
);

	localparam int SW = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN,
		S_SHUP,
		S_SHDN,
		S_POP,
		S_PUT,
		S_RD,
		S_RDV,
		S_FIN
	} state_t;

	state_t               state_q;
	func_t                func_q;
	logic [KEY_BITS-1:0]  key_q;
	logic [CHILD_W-1:0]   anchor_q;
	logic [CHILD_W-1:0]   fresh_q;
	logic [CNT_W-1:0]     pos_q;
	logic [CNT_W-1:0]     ptr_q;
	logic [CNT_W-1:0]     used_q;
	logic [CHILD_W-1:0]   prev_child_q;
	result_t              res_q;
	logic                 data_vld_s1;
	logic [CNT_W-1:0]     data_idx_s1;

	func_t                fn;
	logic [KEY_BITS-1:0]  rd_key;
	logic [CHILD_W-1:0]   rd_child;
	logic [CNT_W-1:0]     used_m1;
	logic [CNT_W-1:0]     idx_up;
	logic [CNT_W-1:0]     idx_dn;
	logic                 last_data;
	logic                 scan_stop;
	logic                 issue;
	logic [SW-1:0]        in_slot;
	logic [SW-1:0]        in_used;
	logic                 slot_bad;

	assign fn        = func_t'(req.func);
	assign rd_key    = mem_rdata[EW-1:CHILD_W];
	assign rd_child  = mem_rdata[CHILD_W-1:0];
	assign used_m1   = used_q - CNT_W'(1);
	assign idx_up    = data_idx_s1 + CNT_W'(1);
	assign idx_dn    = data_idx_s1 - CNT_W'(1);
	assign last_data = (data_idx_s1 == used_m1);
	assign in_slot   = SW'(req.slot);
	assign in_used   = SW'(used_q);
	assign slot_bad  = (in_slot >= in_used);

	// scan has its answer in this cycle, so no further read goes out
	assign scan_stop = data_vld_s1 && ((func_q == FN_LOOKUP) ?
		((data_idx_s1 != '0 && key_q < rd_key) || last_data) :
		(rd_child == anchor_q || last_data));

	assign req.ready = (state_q == S_IDLE);
	assign mem_raddr = ptr_q[IDX_W-1:0];
	assign res_vld   = (state_q == S_FIN);

	always_comb begin
		res = res_q;
		res.entry_count = COUNT_W'(used_q);
	end

	// a read is issued from ptr_q while the walk has entries left and, in a scan, no answer yet
	always_comb begin
		unique case (state_q)
			S_SCAN:  issue = (ptr_q < used_q) && !scan_stop;
			S_SHUP:  issue = (ptr_q > pos_q);
			S_SHDN:  issue = (ptr_q < used_q);
			default: issue = 1'b0;
		endcase
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = ptr_q[IDX_W-1:0];
		mem_wdata = {key_q, fresh_q};
		unique case (state_q)
			S_POP: begin
				mem_we    = 1'b1;
				mem_waddr = '0;
				mem_wdata = {key_q, anchor_q};
			end
			S_PUT: begin
				mem_we = 1'b1;
			end
			S_SHUP: begin
				mem_we    = data_vld_s1;
				mem_waddr = idx_up[IDX_W-1:0];
				mem_wdata = mem_rdata;
			end
			S_SHDN: begin
				mem_we    = data_vld_s1;
				mem_waddr = idx_dn[IDX_W-1:0];
				mem_wdata = mem_rdata;
			end
			S_RDV: begin
				// key write keeps the stored child
				mem_we    = (func_q == FN_WRITE_KEY);
				mem_wdata = {key_q, rd_child};
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			func_q       <= FN_LOOKUP;
			key_q        <= '0;
			anchor_q     <= '0;
			fresh_q      <= '0;
			pos_q        <= '0;
			ptr_q        <= '0;
			used_q       <= '0;
			prev_child_q <= '0;
			res_q        <= '0;
			data_vld_s1  <= 1'b0;
			data_idx_s1  <= '0;
		end else begin
			data_vld_s1 <= issue;
			data_idx_s1 <= ptr_q;
			if (issue) begin
				ptr_q <= (state_q == S_SHUP) ? ptr_q - CNT_W'(1) : ptr_q + CNT_W'(1);
			end
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						func_q   <= fn;
						key_q    <= KEY_BITS'(req.key_value);
						anchor_q <= req.anchor_child;
						fresh_q  <= req.new_child;
						res_q    <= '0;
						unique case (fn)
							FN_LOOKUP: begin
								if (used_q == '0) begin
									res_q.status <= ST_BAD_SLOT;
									state_q      <= S_FIN;
								end else begin
									ptr_q   <= '0;
									state_q <= S_SCAN;
								end
							end
							FN_POPULATE: begin
								state_q <= S_POP;
							end
							FN_INSERT: begin
								if (used_q >= CNT_W'(MAX_ENTRIES)) begin
									res_q.status <= ST_FULL;
									state_q      <= S_FIN;
								end else if (used_q == '0) begin
									res_q.status <= ST_NOT_FOUND;
									state_q      <= S_FIN;
								end else begin
									ptr_q   <= '0;
									state_q <= S_SCAN;
								end
							end
							FN_REMOVE: begin
								if (slot_bad) begin
									res_q.status <= ST_BAD_SLOT;
									state_q      <= S_FIN;
								end else if (in_slot + SW'(1) == in_used) begin
									// last entry goes without any shift
									used_q  <= used_m1;
									state_q <= S_FIN;
								end else begin
									ptr_q   <= CNT_W'(req.slot) + CNT_W'(1);
									state_q <= S_SHDN;
								end
							end
							FN_TAKE_ONLY: begin
								if (used_q != CNT_W'(1)) begin
									res_q.status <= ST_NOT_SINGLE;
									state_q      <= S_FIN;
								end else begin
									ptr_q   <= '0;
									state_q <= S_RD;
								end
							end
							FN_FIND: begin
								if (used_q == '0) begin
									res_q.status <= ST_NOT_FOUND;
									state_q      <= S_FIN;
								end else begin
									ptr_q   <= '0;
									state_q <= S_SCAN;
								end
							end
							FN_READ: begin
								if (slot_bad) begin
									res_q.status <= ST_BAD_SLOT;
									state_q      <= S_FIN;
								end else begin
									ptr_q   <= CNT_W'(req.slot);
									state_q <= S_RD;
								end
							end
							FN_WRITE_KEY: begin
								if (slot_bad || req.slot == '0) begin
									res_q.status <= ST_BAD_SLOT;
									state_q      <= S_FIN;
								end else begin
									ptr_q   <= CNT_W'(req.slot);
									state_q <= S_RD;
								end
							end
						endcase
					end
				end
				S_SCAN: begin
					if (data_vld_s1) begin
						if (func_q == FN_LOOKUP) begin
							if (data_idx_s1 != '0 && key_q < rd_key) begin
								res_q.child_out <= prev_child_q;
								state_q         <= S_FIN;
							end else if (last_data) begin
								res_q.child_out <= rd_child;
								state_q         <= S_FIN;
							end else begin
								prev_child_q <= rd_child;
							end
						end else if (rd_child == anchor_q) begin
							res_q.slot_out <= SLOT_W'(data_idx_s1);
							if (func_q == FN_FIND) begin
								state_q <= S_FIN;
							end else begin
								pos_q <= data_idx_s1;
								if (last_data) begin
									ptr_q   <= idx_up;
									state_q <= S_PUT;
								end else begin
									// move entries from the top down, one a cycle
									ptr_q   <= used_m1;
									state_q <= S_SHUP;
								end
							end
						end else if (last_data) begin
							res_q.status <= ST_NOT_FOUND;
							state_q      <= S_FIN;
						end
					end
				end
				S_SHUP: begin
					if (data_vld_s1 && data_idx_s1 == pos_q + CNT_W'(1)) begin
						ptr_q   <= data_idx_s1;
						state_q <= S_PUT;
					end
				end
				S_SHDN: begin
					if (data_vld_s1 && last_data) begin
						used_q  <= used_m1;
						state_q <= S_FIN;
					end
				end
				S_POP: begin
					ptr_q   <= CNT_W'(1);
					state_q <= S_PUT;
				end
				S_PUT: begin
					used_q  <= (func_q == FN_POPULATE) ? CNT_W'(2) : used_q + CNT_W'(1);
					state_q <= S_FIN;
				end
				S_RD: begin
					state_q <= S_RDV;
				end
				S_RDV: begin
					if (func_q == FN_TAKE_ONLY) begin
						res_q.child_out <= rd_child;
						used_q          <= '0;
					end else if (func_q == FN_READ) begin
						res_q.child_out <= rd_child;
						res_q.key_out   <= KEY_W'(rd_key);
					end
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (res_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CNT_W'(MAX_ENTRIES))
		else $error("entry count beyond node capacity");

	a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request taken while an operation is in flight");

	a_no_write_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !mem_we)
		else $error("entry memory written while idle");

	a_walk_inside_node: assert property (@(posedge clk) disable iff (!arst_n)
		data_vld_s1 |-> (data_idx_s1 < used_q))
		else $error("walk touched an entry beyond the count");

endmodule

// ----- rtl/core/btree_internal_node_engine_top.sv -----
// top level of the b+ tree internal node engine: sequencer, entry memory and
// result register; depends on bine_pkg, bine_req_if, bine_rsp_if, bine_entry_ram, bine_ctrl
//
//   port  dir  transfer when        carries
//   req   in   req.valid & ready    func, key_value, anchor_child, new_child, slot
//   rsp   out  rsp.valid & ready    child_out, key_out, slot_out, entry_count, status
//
// lookup and find scan the entries; insert scans, then shifts the entries above the anchor
// up unless the anchor is the last entry; remove shifts the entries above the slot down.
// single-slot operations and populate need no walk. the single read port of the entry
// memory, one entry per cycle, paces the walks.
// reset clears the entry count and the control and output registers, not the entry memory;
// entries hold nothing until written. a new request is taken while the previous result waits in the output register.
module btree_internal_node_engine_top import bine_pkg::*; #(
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
	parameter int KEY_BITS = KEY_BITS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	bine_req_if.sink  req,
	bine_rsp_if.source rsp
);

	localparam int IDX_W = $clog2(MAX_ENTRIES);
	localparam int EW    = KEY_BITS + CHILD_W;

	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	logic [EW-1:0]    mem_wdata;
	logic [IDX_W-1:0] mem_raddr;
	logic [EW-1:0]    mem_rdata;
	logic             res_vld;
	logic             res_free;
	result_t          res;
	logic             out_vld_q;
	result_t          out_q;

	bine_entry_ram #(
		.DEPTH (MAX_ENTRIES),
		.WIDTH (EW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	bine_ctrl #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.KEY_BITS    (KEY_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata),
		.res_free  (res_free),
		.res_vld   (res_vld),
		.res       (res)
	);

	// output register frees up in the same cycle its result transfers
	assign res_free = !out_vld_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			out_q     <= '0;
		end else if (res_vld && res_free) begin
			out_vld_q <= 1'b1;
			out_q     <= res;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	assign rsp.valid       = out_vld_q;
	assign rsp.child_out   = out_q.child_out;
	assign rsp.key_out     = out_q.key_out;
	assign rsp.slot_out    = out_q.slot_out;
	assign rsp.entry_count = out_q.entry_count;
	assign rsp.status      = out_q.status;

endmodule
